// ===== src/rpb_pkg.sv =====
//------------------------------------------------------------------------------
// rpb_pkg
// Shared types and constants of the relative position bias lookup.
//------------------------------------------------------------------------------
package rpb_pkg;

   // Command codes carried by an input beat.
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_NUM_HEADS     = 2'd0;
   localparam logic [1:0] REG_NUM_BUCKETS   = 2'd1;
   localparam logic [1:0] REG_DIST_LIMIT    = 2'd2;
   localparam logic [1:0] REG_BIDIRECTIONAL = 2'd3;

   // Argument selects of the shared log unit.
   localparam logic [1:0] LSEL_DIST  = 2'd0;
   localparam logic [1:0] LSEL_EXACT = 2'd1;
   localparam logic [1:0] LSEL_LIMIT = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_START,
      ST_LOG_NORM,
      ST_LOG_SQ,
      ST_LOG_DONE,
      ST_DIV,
      ST_MUL,
      ST_FINISH,
      ST_READ,
      ST_EMIT
   } state_type;

   // States of the log unit.
   typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ, L_DONE} lstate_type;

   // Request from the sequencer to the log unit, and its reply.
   typedef struct packed {
      logic        start;
      logic [15:0] x;
   } log_req_type;

   typedef struct packed {
      logic        done;
      logic [20:0] value;
   } log_rsp_type;

endpackage

// ===== src/rpb_ram.sv =====
//------------------------------------------------------------------------------
// rpb_ram
// Generic RAM with one write port and one registered read port.
//------------------------------------------------------------------------------
module rpb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/rpb_log2.sv =====
//------------------------------------------------------------------------------
// rpb_log2
// Iterative log2 in Q5.16: normalize one bit a cycle, then one squaring a cycle.
//------------------------------------------------------------------------------
module rpb_log2
   import rpb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  log_req_type req,
   output log_rsp_type rsp
);

   lstate_type  st_ff, st_in;
   logic [15:0] x_ff, x_in;
   logic [4:0]  e_ff, e_in;
   logic [31:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] sq;
   logic [33:0] sqs;

   // Squaring of the Q2.30 mantissa.
   assign sq  = {32'd0, m_ff} * {32'd0, m_ff};
   assign sqs = sq[63:30];

   // Next state of the unit.
   always_comb begin
      st_in   = st_ff;
      x_in    = x_ff;
      e_in    = e_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      cnt_in  = cnt_ff;
      case (st_ff)
         L_IDLE: begin
            if (req.start) begin
               x_in   = req.x;
               e_in   = 5'd15;
               cnt_in = 5'd0;
               st_in  = L_NORM;
            end
         end
         L_NORM: begin
            // Search for the leading one, one position a cycle.
            if (x_ff[15] || e_ff == 5'd0) begin
               m_in    = {2'b01, x_ff[14:0], 15'd0};
               frac_in = 16'd0;
               st_in   = L_SQ;
            end else begin
               x_in = {x_ff[14:0], 1'b0};
               e_in = e_ff - 5'd1;
            end
         end
         L_SQ: begin
            if (sqs >= 34'h080000000) begin
               frac_in = {frac_ff[14:0], 1'b1};
               m_in    = sqs[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               m_in    = sqs[31:0];
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               st_in = L_DONE;
            end
         end
         L_DONE: st_in = L_IDLE;
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= L_IDLE;
      end else begin
         st_ff <= st_in;
      end
      x_ff    <= x_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
   end

   // A zero input reads as zero.
   assign rsp.done  = (st_ff == L_DONE);
   assign rsp.value = (x_ff == 16'd0) ? 21'd0 : {e_ff, frac_ff};

endmodule

// ===== src/relative_position_bias_lookup_top.sv =====
//------------------------------------------------------------------------------
// relative_position_bias_lookup_top
// Relative position bucketing with a per-bucket, per-head bias table.
//------------------------------------------------------------------------------
// Channel | Direction | Ports
// req     | in        | req_valid/req_ready, cmd, positions, table entry
// rsp     | out       | rsp_valid/rsp_ready, head, bias_value, bucket, last
// csr     | in        | APB-style register port, pready always high
//
// A write beat goes straight to the table. A compute beat whose distance falls
// in an exact bucket, or whose distance limit is short, skips the log path.
// Otherwise it runs three log2 passes in one shared squaring unit, a 16-step
// restoring divide and one multiply. Then one table read per head follows.
// Reset is synchronous; the table is undefined until written. A stalled
// result holds the sequencer.
//------------------------------------------------------------------------------
module relative_position_bias_lookup_top
   import rpb_pkg::*;
#(
   parameter int MAX_BUCKETS = 64,
   parameter int MAX_HEADS   = 16,
   parameter int MAX_SEQ     = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [11:0] req_query_pos,
   input  logic [11:0] req_key_pos,
   input  logic [5:0]  req_entry_bucket,
   input  logic [3:0]  req_entry_head,
   input  logic [31:0] req_entry_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_head,
   output logic [31:0] rsp_bias_value,
   output logic [5:0]  rsp_bucket,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int DEPTH = MAX_BUCKETS * MAX_HEADS;
   localparam int AW    = $clog2(DEPTH);

   // Configuration registers.
   logic [4:0]  nh_ff;
   logic [6:0]  nb_ff;
   logic [12:0] md_ff;
   logic        bd_ff;
   logic        csr_wr;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         nh_ff <= 5'd8;
         nb_ff <= 7'd32;
         md_ff <= 13'd128;
         bd_ff <= 1'b1;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_NUM_HEADS:     nh_ff <= pwdata[4:0];
            REG_NUM_BUCKETS:   nb_ff <= pwdata[6:0];
            REG_DIST_LIMIT:    md_ff <= pwdata[12:0];
            REG_BIDIRECTIONAL: bd_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_NUM_HEADS:     prdata = {27'd0, nh_ff};
         REG_NUM_BUCKETS:   prdata = {25'd0, nb_ff};
         REG_DIST_LIMIT:    prdata = {19'd0, md_ff};
         REG_BIDIRECTIONAL: prdata = {31'd0, bd_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // Clamped register views.
   logic [6:0] nb_c;
   logic [6:0] eb;
   logic [6:0] me;
   logic [4:0] nh_c;
   always_comb begin
      nb_c = nb_ff;
      if (nb_ff < 7'd4) nb_c = 7'd4;
      if (32'(nb_ff) > MAX_BUCKETS) nb_c = 7'(MAX_BUCKETS);
      eb = bd_ff ? {1'b0, nb_c[6:1]} : nb_c;
      me = {1'b0, eb[6:1]};
      nh_c = nh_ff;
      if (nh_ff == 5'd0) nh_c = 5'd1;
      if (32'(nh_ff) > MAX_HEADS) nh_c = 5'(MAX_HEADS);
      if (nh_c > 5'd16) nh_c = 5'd16;
   end

   // Sequencer registers.
   state_type   st_ff, st_in;
   logic [1:0]  lsel_ff, lsel_in;
   logic [12:0] n_ff, n_in;
   logic        pos_ff, pos_in;
   logic [20:0] ln_ff, ln_in, lm_ff, lm_in, ld_ff, ld_in;
   logic [36:0] rem_ff, rem_in;
   logic [16:0] q_ff, q_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [6:0]  bkt_ff, bkt_in;
   logic [4:0]  h_ff, h_in;
   logic        ovf_ff, ovf_in;
   logic [22:0] prod;

   // Shared log unit.
   log_req_type lreq;
   log_rsp_type lrsp;
   rpb_log2 u_log (.clock(clock), .reset(reset), .req(lreq), .rsp(lrsp));

   // Table memory.
   logic          tbl_we;
   logic [AW-1:0] tbl_waddr, tbl_raddr;
   logic [31:0]   tbl_rdata;
   rpb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(tbl_we), .waddr(tbl_waddr), .wdata(req_entry_value),
      .raddr(tbl_raddr), .rdata(tbl_rdata)
   );

   logic req_acc;
   assign req_acc = req_valid && req_ready;
   assign tbl_we  = req_acc && (req_cmd == CMD_WRITE) &&
                    (32'(req_entry_bucket) < MAX_BUCKETS) &&
                    (32'(req_entry_head) < MAX_HEADS);
   assign tbl_waddr = AW'(32'(req_entry_bucket) * MAX_HEADS + 32'(req_entry_head));
   assign tbl_raddr = AW'(32'(bkt_ff) * MAX_HEADS + 32'(h_ff));

   // Clamped positions and distance.
   logic [11:0] qp, kp;
   logic [12:0] rel_mag;
   logic        rel_pos, rel_neg;
   always_comb begin
      qp = (32'(req_query_pos) > MAX_SEQ - 1) ? 12'(MAX_SEQ - 1) : req_query_pos;
      kp = (32'(req_key_pos) > MAX_SEQ - 1) ? 12'(MAX_SEQ - 1) : req_key_pos;
      rel_pos = kp > qp;
      rel_neg = kp < qp;
      rel_mag = rel_pos ? {1'b0, kp - qp} : {1'b0, qp - kp};
   end

   // Divider step and scale multiply.
   logic [37:0] dtry;
   assign dtry = {rem_ff, 1'b0} - {17'd0, ld_ff};
   assign prod = 23'(eb - me) * q_ff[15:0];

   // Next state logic.
   always_comb begin
      st_in   = st_ff;
      lsel_in = lsel_ff;
      n_in    = n_ff;
      pos_in  = pos_ff;
      ln_in   = ln_ff;
      lm_in   = lm_ff;
      ld_in   = ld_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dcnt_in = dcnt_ff;
      bkt_in  = bkt_ff;
      h_in    = h_ff;
      ovf_in  = ovf_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_acc && req_cmd == CMD_COMPUTE) begin
               pos_in = bd_ff && rel_pos;
               n_in   = (bd_ff || rel_neg) ? rel_mag : 13'd0;
               h_in   = 5'd0;
               st_in  = ST_LOG_START;
            end
         end
         ST_LOG_START: begin
            if (n_ff < {6'd0, me}) begin
               bkt_in = n_ff[6:0];
               st_in  = ST_FINISH;
            end else if (md_ff <= {6'd0, me}) begin
               bkt_in = eb - 7'd1;
               st_in  = ST_FINISH;
            end else begin
               lsel_in = LSEL_DIST;
               st_in   = ST_LOG_NORM;
            end
         end
         ST_LOG_NORM: st_in = ST_LOG_SQ;
         ST_LOG_SQ: begin
            if (lrsp.done) begin
               case (lsel_ff)
                  LSEL_DIST: begin
                     ln_in   = lrsp.value;
                     lsel_in = LSEL_EXACT;
                     st_in   = ST_LOG_NORM;
                  end
                  LSEL_EXACT: begin
                     lm_in   = lrsp.value;
                     lsel_in = LSEL_LIMIT;
                     st_in   = ST_LOG_NORM;
                  end
                  default: begin
                     ld_in = lrsp.value;
                     st_in = ST_LOG_DONE;
                  end
               endcase
            end
         end
         ST_LOG_DONE: begin
            ld_in  = ld_ff - lm_ff;
            rem_in = {16'd0, ln_ff - lm_ff};
            q_in   = 17'd0;
            dcnt_in = 5'd0;
            ovf_in = 1'b0;
            if (ld_ff == lm_ff) begin
               bkt_in = eb - 7'd1;
               st_in  = ST_FINISH;
            end else begin
               st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // One fraction bit a cycle, 16 bits in all. A numerator at or above
            // the divisor keeps every bit set, which is the saturated ratio.
            if (!dtry[37]) begin
               rem_in = dtry[36:0];
               q_in   = {q_ff[15:0], 1'b1};
               if (q_ff[16]) ovf_in = 1'b1;
            end else begin
               rem_in = {rem_ff[35:0], 1'b0};
               q_in   = {q_ff[15:0], 1'b0};
               if (q_ff[16]) ovf_in = 1'b1;
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd15) begin
               st_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (ovf_ff || q_ff[16]) q_in = 17'h0FFFF;
            st_in = ST_FINISH;
            if (!(ovf_ff || q_ff[16])) begin
               bkt_in = me + prod[22:16];
            end else begin
               bkt_in = me + 7'(({7'd0, eb - me} * 23'h0FFFF) >> 16);
            end
            if (bkt_in > eb - 7'd1) bkt_in = eb - 7'd1;
         end
         ST_FINISH: begin
            bkt_in = bkt_ff + (pos_ff ? eb : 7'd0);
            if (32'(bkt_in) > MAX_BUCKETS - 1) bkt_in = 7'(MAX_BUCKETS - 1);
            st_in = ST_READ;
         end
         ST_READ: st_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_ready) begin
               h_in = h_ff + 5'd1;
               st_in = (h_ff == nh_c - 5'd1) ? ST_IDLE : ST_READ;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // The log argument: the distance, then the exact limit, then the distance limit.
   always_comb begin
      lreq.start = (st_ff == ST_LOG_NORM);
      case (lsel_ff)
         LSEL_DIST:  lreq.x = {3'd0, n_ff};
         LSEL_EXACT: lreq.x = {9'd0, me};
         default:    lreq.x = {3'd0, md_ff};
      endcase
   end

   // Output and handshake logic.
   always_comb begin
      req_ready  = (st_ff == ST_IDLE);
      rsp_valid  = (st_ff == ST_EMIT);
      rsp_head   = h_ff[3:0];
      rsp_bias_value = tbl_rdata;
      rsp_bucket = bkt_ff[5:0];
      rsp_last   = (h_ff == nh_c - 5'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         h_ff  <= 5'd0;
      end else begin
         st_ff <= st_in;
         h_ff  <= h_in;
      end
      lsel_ff <= lsel_in;
      n_ff    <= n_in;
      pos_ff  <= pos_in;
      ln_ff   <= ln_in;
      lm_ff   <= lm_in;
      ld_ff   <= ld_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dcnt_ff <= dcnt_in;
      bkt_ff  <= bkt_in;
      ovf_ff  <= ovf_in;
   end

`ifndef SYNTHESIS
   // No input beat is taken while results are pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted during emission");

   // A stalled result keeps its head and bucket.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_head) && $stable(rsp_bucket))
      else $error("result changed while stalled");

   // The last beat returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("sequencer not idle after last beat");
`endif

endmodule
